FILE: rtl/gpio_port_with_edge_detect_defines.svh
// Assertion macros for the GPIO port with edge detection.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef GPIO_PORT_WITH_EDGE_DETECT_DEFINES_SVH
`define GPIO_PORT_WITH_EDGE_DETECT_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define GPE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpio port: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define GPE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpio port: next-cycle check failed");

`endif

FILE: rtl/gpe_pkg.sv
// Shared types and constants of the GPIO port with edge detection.
// No dependencies.
`timescale 1ns / 1ps

package gpe_pkg;

    // Number of pins that have an interrupt line of their own.
    localparam int unsigned IRQ_LOW_COUNT = 11;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2
    } gpe_action_t;

    // Register numbers; byte offset is the number times four.
    typedef enum logic [2:0] {
        REG_LEVEL  = 3'd0,
        REG_DIR    = 3'd1,
        REG_SET    = 3'd2,
        REG_CLR    = 3'd3,
        REG_RISE   = 3'd4,
        REG_FALL   = 3'd5,
        REG_STATUS = 3'd6,
        REG_ALT    = 3'd7
    } gpe_reg_t;

    // Status of the input stage as seen by the core and the output stage.
    typedef struct packed {
        logic valid;   // input register holds a beat
        logic commit;  // that beat moves to the result register this cycle
    } gpe_stage_t;

endpackage

FILE: rtl/gpe_if.sv
// Request and response channel interfaces of the GPIO port.
// Depends on gpe_pkg for the interrupt line count.
`timescale 1ns / 1ps

interface gpe_req_if
    import gpe_pkg::*;
#(
    parameter int unsigned PIN_COUNT = 28
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           action;
    logic [2:0]           reg_index;
    logic [PIN_COUNT-1:0] write_data;
    logic [PIN_COUNT-1:0] pin_levels;

    modport source (output valid, action, reg_index, write_data, pin_levels, input ready);
    modport sink (input valid, action, reg_index, write_data, pin_levels, output ready);
endinterface

interface gpe_rsp_if
    import gpe_pkg::*;
#(
    parameter int unsigned PIN_COUNT = 28
);
    logic                     valid;
    logic                     ready;
    logic [PIN_COUNT-1:0]     read_data;
    logic [PIN_COUNT-1:0]     drive_levels;
    logic [PIN_COUNT-1:0]     drive_enable;
    logic [IRQ_LOW_COUNT-1:0] irq_low_pins;
    logic                     irq_high_pins;

    modport source (output valid, read_data, drive_levels, drive_enable, irq_low_pins,
                    irq_high_pins, input ready);
    modport sink (input valid, read_data, drive_levels, drive_enable, irq_low_pins,
                  irq_high_pins, output ready);
endinterface

FILE: rtl/gpe_in_stage.sv
// Input register of the GPIO port: captures one request beat per cycle unless a held beat cannot advance.
// Depends on gpe_pkg and gpe_req_if.
`timescale 1ns / 1ps

module gpe_in_stage
    import gpe_pkg::*;
#(
    parameter int unsigned PIN_COUNT = 28
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    gpe_req_if.sink              req,
    input  logic                 advance,
    output gpe_stage_t           stage,
    output logic [1:0]           action,
    output logic [2:0]           reg_index,
    output logic [PIN_COUNT-1:0] write_data,
    output logic [PIN_COUNT-1:0] pin_levels
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [1:0]           action_reg;
    logic [2:0]           reg_index_reg;
    logic [PIN_COUNT-1:0] write_data_reg;
    logic [PIN_COUNT-1:0] pin_levels_reg;
    logic                 accept;

    // Take a new beat when empty or when the held beat leaves this cycle.
    assign req.ready = !valid_reg || advance;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg     <= req.action;
            reg_index_reg  <= req.reg_index;
            write_data_reg <= req.write_data;
            pin_levels_reg <= req.pin_levels;
        end
    end

    assign stage.valid  = valid_reg;
    assign stage.commit = valid_reg && advance;
    assign action       = action_reg;
    assign reg_index    = reg_index_reg;
    assign write_data   = write_data_reg;
    assign pin_levels   = pin_levels_reg;

endmodule

FILE: rtl/gpe_core.sv
// Register file, edge detection and read mux of the GPIO port.
// Depends on gpe_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "gpio_port_with_edge_detect_defines.svh"

module gpe_core
    import gpe_pkg::*;
#(
    parameter int unsigned PIN_COUNT = 28
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  gpe_stage_t               stage,
    input  logic [1:0]               action,
    input  logic [2:0]               reg_index,
    input  logic [PIN_COUNT-1:0]     write_data,
    input  logic [PIN_COUNT-1:0]     pin_levels,
    output logic [PIN_COUNT-1:0]     read_data,
    output logic [PIN_COUNT-1:0]     drive_levels,
    output logic [PIN_COUNT-1:0]     drive_enable,
    output logic [IRQ_LOW_COUNT-1:0] irq_low_pins,
    output logic                     irq_high_pins
);

    logic [PIN_COUNT-1:0] prev_pins_reg;
    logic [PIN_COUNT-1:0] latch_reg;
    logic [PIN_COUNT-1:0] latch_next;
    logic [PIN_COUNT-1:0] dir_reg;
    logic [PIN_COUNT-1:0] dir_next;
    logic [PIN_COUNT-1:0] rise_reg;
    logic [PIN_COUNT-1:0] rise_next;
    logic [PIN_COUNT-1:0] fall_reg;
    logic [PIN_COUNT-1:0] fall_next;
    logic [PIN_COUNT-1:0] status_reg;
    logic [PIN_COUNT-1:0] status_next;
    logic [PIN_COUNT-1:0] alt_reg;
    logic [PIN_COUNT-1:0] alt_next;
    logic [PIN_COUNT-1:0] status_clear;
    logic [PIN_COUNT-1:0] rising;
    logic [PIN_COUNT-1:0] falling;
    logic                 is_write;
    logic                 is_read;

    assign is_read  = (gpe_action_t'(action) == ACT_READ);
    assign is_write = (gpe_action_t'(action) == ACT_WRITE);

    // Edges use the enables held before this beat.
    assign rising  = pin_levels & ~prev_pins_reg & rise_reg;
    assign falling = ~pin_levels & prev_pins_reg & fall_reg;

    always_comb
    begin
        latch_next   = latch_reg;
        dir_next     = dir_reg;
        rise_next    = rise_reg;
        fall_next    = fall_reg;
        alt_next     = alt_reg;
        status_clear = '0;
        if (is_write)
        begin
            case (gpe_reg_t'(reg_index))
                REG_DIR:    dir_next     = write_data;
                REG_SET:    latch_next   = latch_reg | write_data;
                REG_CLR:    latch_next   = latch_reg & ~write_data;
                REG_RISE:   rise_next    = write_data;
                REG_FALL:   fall_next    = write_data;
                REG_STATUS: status_clear = write_data;
                REG_ALT:    alt_next     = write_data;
                default:    status_clear = '0;
            endcase
        end
        // Clear first, then set, so a new edge is never lost.
        status_next = (status_reg & ~status_clear) | rising | falling;
    end

    always_comb
    begin
        read_data = '0;
        if (is_read)
        begin
            case (gpe_reg_t'(reg_index))
                REG_LEVEL:  read_data = pin_levels;
                REG_DIR:    read_data = dir_reg;
                REG_RISE:   read_data = rise_reg;
                REG_FALL:   read_data = fall_reg;
                REG_STATUS: read_data = status_reg;
                REG_ALT:    read_data = alt_reg;
                default:    read_data = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pins_reg <= '0;
            latch_reg     <= '0;
            dir_reg       <= '0;
            rise_reg      <= '0;
            fall_reg      <= '0;
            status_reg    <= '0;
            alt_reg       <= '0;
        end
        else if (stage.commit)
        begin
            prev_pins_reg <= pin_levels;
            latch_reg     <= latch_next;
            dir_reg       <= dir_next;
            rise_reg      <= rise_next;
            fall_reg      <= fall_next;
            status_reg    <= status_next;
            alt_reg       <= alt_next;
        end
    end

    assign drive_levels  = latch_next;
    assign drive_enable  = dir_next;
    assign irq_low_pins  = status_next[IRQ_LOW_COUNT-1:0];
    assign irq_high_pins = |status_next[PIN_COUNT-1:IRQ_LOW_COUNT];

    `GPE_ASSERT_NXT(a_state_hold, !stage.commit,
        $stable(status_reg) && $stable(latch_reg) && $stable(prev_pins_reg))
    `GPE_ASSERT_NXT(a_status_sticky,
        stage.commit && !(is_write && gpe_reg_t'(reg_index) == REG_STATUS),
        (status_reg & $past(status_reg)) == $past(status_reg))
    `GPE_ASSERT_IMP(a_read_zero, stage.valid && !is_read, read_data == '0)

endmodule

FILE: rtl/gpio_port_with_edge_detect.sv
// Top level of the GPIO port with edge detection: input stage, core, result register.
// Depends on gpe_pkg, gpe_if, gpe_in_stage, gpe_core and the assertion macros header.
`timescale 1ns / 1ps
`include "gpio_port_with_edge_detect_defines.svh"

// GPIO port of PIN_COUNT pins behind eight word registers (level, direction,
// set, clear, rise enable, fall enable, edge status, alternate function).
// Each request beat is a tick, a register read or a register write and also
// carries the pin levels sampled for that beat; every beat compares them with
// the previous sample and latches enabled edges into the edge status register.
// The block takes one beat per clock while the response sink keeps up and
// returns one response beat for each: a beat lands in the input register,
// passes through the register file and edge logic, and is then captured in
// the result register, which drives response valid. The result register is the
// only buffer on the response side; while the sink stalls, one more beat waits
// in the input register before req.ready drops. A read sees register contents
// from before its own beat, except the level register, which returns the pins
// of the beat. After reset the previous sample is zero, but so are the edge
// enables, so no edge is latched until an enable is written.

module gpio_port_with_edge_detect
    import gpe_pkg::*;
#(
    parameter int unsigned PIN_COUNT = 28
)
(
    input  logic      clk,
    input  logic      rst_n,
    gpe_req_if.sink   req,
    gpe_rsp_if.source rsp
);

    gpe_stage_t               stage;
    logic                     advance;
    logic [1:0]               action;
    logic [2:0]               reg_index;
    logic [PIN_COUNT-1:0]     write_data;
    logic [PIN_COUNT-1:0]     pin_levels;
    logic [PIN_COUNT-1:0]     read_data;
    logic [PIN_COUNT-1:0]     drive_levels;
    logic [PIN_COUNT-1:0]     drive_enable;
    logic [IRQ_LOW_COUNT-1:0] irq_low_pins;
    logic                     irq_high_pins;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [PIN_COUNT-1:0]     read_data_reg;
    logic [PIN_COUNT-1:0]     drive_levels_reg;
    logic [PIN_COUNT-1:0]     drive_enable_reg;
    logic [IRQ_LOW_COUNT-1:0] irq_low_reg;
    logic                     irq_high_reg;

    // Advance whenever the result register is empty or is being drained.
    assign advance = !out_valid_reg || rsp.ready;

    gpe_in_stage #(
        .PIN_COUNT (PIN_COUNT)
    ) u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (advance),
        .stage      (stage),
        .action     (action),
        .reg_index  (reg_index),
        .write_data (write_data),
        .pin_levels (pin_levels)
    );

    gpe_core #(
        .PIN_COUNT (PIN_COUNT)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .stage         (stage),
        .action        (action),
        .reg_index     (reg_index),
        .write_data    (write_data),
        .pin_levels    (pin_levels),
        .read_data     (read_data),
        .drive_levels  (drive_levels),
        .drive_enable  (drive_enable),
        .irq_low_pins  (irq_low_pins),
        .irq_high_pins (irq_high_pins)
    );

    // Hold the response while stalled; refill from the input stage on advance.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = stage.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage.commit)
        begin
            read_data_reg    <= read_data;
            drive_levels_reg <= drive_levels;
            drive_enable_reg <= drive_enable;
            irq_low_reg      <= irq_low_pins;
            irq_high_reg     <= irq_high_pins;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.read_data     = read_data_reg;
    assign rsp.drive_levels  = drive_levels_reg;
    assign rsp.drive_enable  = drive_enable_reg;
    assign rsp.irq_low_pins  = irq_low_reg;
    assign rsp.irq_high_pins = irq_high_reg;

    `GPE_ASSERT_NXT(a_commit_fills, stage.commit, out_valid_reg)
    `GPE_ASSERT_IMP(a_no_overrun, out_valid_reg && !rsp.ready && stage.valid, !req.ready)
    `GPE_ASSERT_NXT(a_accept_lands, req.valid && req.ready, stage.valid)

endmodule
